// ----- rtl/core/a429_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// a429_pkg
// Shared types and constants for the ARINC 429 word codec.
// ----------------------------------------------------------------------------
package a429_pkg;

   typedef enum logic [1:0] {
      CMD_BNR      = 2'd0,
      CMD_BCD      = 2'd1,
      CMD_DISCRETE = 2'd2,
      CMD_DECODE   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      CSR_RANGE_MIN  = 2'd0,
      CSR_RANGE_SPAN = 2'd1,
      CSR_DATA_BITS  = 2'd2
   } csr_index_type;

   localparam logic [18:0] CODE_MAX    = 19'h3FFFF;
   localparam logic [18:0] CODE_MIN    = 19'h40000;
   localparam logic [4:0]  BITS_LO     = 5'd2;
   localparam logic [4:0]  BITS_HI     = 5'd19;
   localparam int          DIV_STEPS   = 19;
   localparam int          NUM_W       = 51;

   typedef struct packed {
      logic [1:0]  command;
      logic [7:0]  label;
      logic [1:0]  sdi;
      logic [1:0]  ssm;
      logic [18:0] data_field;
      logic [31:0] rx_word;
   } item_type;

endpackage

// ----- rtl/core/a429_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// a429 channel interfaces
// Request, response and register write channels of the codec.
// ----------------------------------------------------------------------------
interface a429_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  command;
   logic [7:0]  label;
   logic [1:0]  sdi;
   logic [1:0]  ssm;
   logic [31:0] bnr_value;
   logic [18:0] data_field;
   logic [31:0] rx_word;
   modport source (output valid, command, label, sdi, ssm, bnr_value, data_field, rx_word,
                   input ready);
   modport sink   (input valid, command, label, sdi, ssm, bnr_value, data_field, rx_word,
                   output ready);
endinterface

interface a429_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] word;
   logic [7:0]  label_out;
   logic [1:0]  sdi_out;
   logic [1:0]  ssm_out;
   logic        data_valid;
   logic [18:0] data_sext;
   logic [31:0] value_out;
   modport source (output valid, word, label_out, sdi_out, ssm_out, data_valid, data_sext,
                   value_out, input ready);
   modport sink   (input valid, word, label_out, sdi_out, ssm_out, data_valid, data_sext,
                   value_out, output ready);
endinterface

interface a429_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [31:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/core/arinc429_word_codec.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arinc429_word_codec
// Packs BNR/BCD/discrete ARINC 429 words or decodes raw words, one request
// per cycle through a 26-stage pipeline with a bit-per-stage divider.
// ----------------------------------------------------------------------------
//  channel | dir | handshake    | payload
//  req     | in  | valid/ready  | command, label, sdi, ssm, bnr_value, data_field, rx_word
//  rsp     | out | valid/ready  | word, fields, data_valid, data_sext, value_out
//  csr     | in  | valid/ready  | index, data (ready always high)
//
//  One request per cycle unless the output stalls; 20 divider stages plus six others.
//  Whole pipeline advances when the output register is empty or taken.
//  Synchronous reset clears valid bits and loads register defaults.
// ----------------------------------------------------------------------------
module arinc429_word_codec
   import a429_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   a429_req_if.sink    req,
   a429_rsp_if.source  rsp,
   a429_csr_if.sink    csr
);

   logic [31:0] min_ff;
   logic [30:0] span_ff;
   logic [4:0]  bits_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff  <= '0;
         span_ff <= 31'd65536;
         bits_ff <= 5'd19;
      end else if (csr.valid && csr.ready) begin
         case (csr.index)
            CSR_RANGE_MIN:  min_ff  <= csr.data;
            CSR_RANGE_SPAN: span_ff <= csr.data[30:0];
            CSR_DATA_BITS:  bits_ff <= csr.data[4:0];
            default: ;
         endcase
      end
   end
   assign csr.ready = 1'b1;

   logic [30:0] span_eff;
   logic [4:0]  bits_eff;
   logic [4:0]  shamt;
   assign span_eff = (span_ff == '0) ? 31'd1 : span_ff;
   assign bits_eff = (bits_ff < BITS_LO) ? BITS_LO : ((bits_ff > BITS_HI) ? BITS_HI : bits_ff);
   assign shamt    = bits_eff - 5'd1;

   logic out_v_ff;
   logic en;
   assign en        = !out_v_ff || rsp.ready;
   assign req.ready = en;

   // stage A: difference
   logic              a_v_ff;
   item_type          a_it_ff;
   logic signed [32:0] a_diff_ff;
   always_ff @(posedge clock) begin
      if (reset) a_v_ff <= 1'b0;
      else if (en) a_v_ff <= req.valid;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         a_it_ff   <= '{req.command, req.label, req.sdi, req.ssm, req.data_field, req.rx_word};
         a_diff_ff <= $signed({req.bnr_value[31], req.bnr_value})
                    - $signed({min_ff[31], min_ff});
      end
   end

   // stage B: magnitude and scaling
   logic              b_v_ff;
   item_type          b_it_ff;
   logic              b_neg_ff;
   logic [NUM_W-1:0]  b_num_ff;
   logic [32:0]       a_mag;
   assign a_mag = a_diff_ff[32] ? (~a_diff_ff + 33'd1) : a_diff_ff;
   always_ff @(posedge clock) begin
      if (reset) b_v_ff <= 1'b0;
      else if (en) b_v_ff <= a_v_ff;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         b_it_ff  <= a_it_ff;
         b_neg_ff <= a_diff_ff[32];
         b_num_ff <= {18'd0, a_mag} << shamt;
      end
   end

   // divider stages: index 0 is the overflow check, then one quotient bit each
   logic             d_v_ff   [0:DIV_STEPS];
   item_type         d_it_ff  [0:DIV_STEPS];
   logic             d_neg_ff [0:DIV_STEPS];
   logic             d_big_ff [0:DIV_STEPS];
   logic [NUM_W-1:0] d_rem_ff [0:DIV_STEPS];
   logic [18:0]      d_quo_ff [0:DIV_STEPS];

   always_ff @(posedge clock) begin
      if (reset) d_v_ff[0] <= 1'b0;
      else if (en) d_v_ff[0] <= b_v_ff;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         d_it_ff[0]  <= b_it_ff;
         d_neg_ff[0] <= b_neg_ff;
         d_big_ff[0] <= b_num_ff >= {1'b0, span_eff, 19'd0};
         d_rem_ff[0] <= b_num_ff;
         d_quo_ff[0] <= '0;
      end
   end

   for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
      localparam int BIT = DIV_STEPS - 1 - g;
      logic [NUM_W-1:0] dsh;
      logic             ge;
      logic [18:0]      quo_in;
      assign dsh    = {20'd0, span_eff} << BIT;
      assign ge     = d_rem_ff[g] >= dsh;
      assign quo_in = d_quo_ff[g] | ({18'd0, ge} << BIT);
      always_ff @(posedge clock) begin
         if (reset) d_v_ff[g+1] <= 1'b0;
         else if (en) d_v_ff[g+1] <= d_v_ff[g];
      end
      always_ff @(posedge clock) begin
         if (en) begin
            d_it_ff[g+1]  <= d_it_ff[g];
            d_neg_ff[g+1] <= d_neg_ff[g];
            d_big_ff[g+1] <= d_big_ff[g];
            d_rem_ff[g+1] <= ge ? (d_rem_ff[g] - dsh) : d_rem_ff[g];
            d_quo_ff[g+1] <= quo_in;
         end
      end
   end

   // stage F: code saturation and word assembly (raw word passed through for decode)
   item_type    f_it;
   logic [18:0] f_q;
   logic [18:0] f_code;
   logic [18:0] f_data;
   logic [30:0] f_body;
   logic [31:0] f_word_in;
   always_comb begin
      f_it = d_it_ff[DIV_STEPS];
      f_q  = d_quo_ff[DIV_STEPS];
      if (d_neg_ff[DIV_STEPS])
         f_code = (d_big_ff[DIV_STEPS] || f_q > CODE_MIN) ? CODE_MIN : (~f_q + 19'd1);
      else
         f_code = (d_big_ff[DIV_STEPS] || f_q[18]) ? CODE_MAX : f_q;
      case (f_it.command)
         CMD_BNR:      f_data = f_it.ssm[1] ? f_code : '0;
         CMD_BCD:      f_data = {2'b00, f_it.data_field[16:0]};
         CMD_DISCRETE: f_data = f_it.data_field;
         default:      f_data = '0;
      endcase
      f_body = {f_it.ssm, f_data, f_it.sdi, f_it.label};
      if (f_it.command == CMD_DECODE) f_word_in = f_it.rx_word;
      else                            f_word_in = {~(^f_body), f_body};
   end

   logic        f_v_ff;
   logic [31:0] f_word_ff;
   always_ff @(posedge clock) begin
      if (reset) f_v_ff <= 1'b0;
      else if (en) f_v_ff <= d_v_ff[DIV_STEPS];
   end
   always_ff @(posedge clock) begin
      if (en) f_word_ff <= f_word_in;
   end

   // stage M: data times span
   logic               m_v_ff;
   logic [31:0]        m_word_ff;
   logic signed [50:0] m_prod_ff;
   always_ff @(posedge clock) begin
      if (reset) m_v_ff <= 1'b0;
      else if (en) m_v_ff <= f_v_ff;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         m_word_ff <= f_word_ff;
         m_prod_ff <= 51'($signed(f_word_ff[28:10])) * 51'($signed({1'b0, span_eff}));
      end
   end

   // stage T: divide by scale, truncating toward zero
   logic               t_v_ff;
   logic [31:0]        t_word_ff;
   logic signed [50:0] t_quot_ff;
   logic signed [50:0] t_bias;
   assign t_bias = m_prod_ff[50] ? $signed((51'd1 << shamt) - 51'd1) : '0;
   always_ff @(posedge clock) begin
      if (reset) t_v_ff <= 1'b0;
      else if (en) t_v_ff <= m_v_ff;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         t_word_ff <= m_word_ff;
         t_quot_ff <= (m_prod_ff + t_bias) >>> shamt;
      end
   end

   // stage O: offset, saturate, output register
   logic signed [51:0] o_sum;
   logic [31:0]        o_val;
   assign o_sum = 52'(t_quot_ff) + 52'($signed(min_ff));
   always_comb begin
      if (o_sum > 52'sh7FFFFFFF)        o_val = 32'h7FFFFFFF;
      else if (o_sum < -52'sh80000000)  o_val = 32'h80000000;
      else                              o_val = o_sum[31:0];
   end

   logic [31:0] out_word_ff;
   logic [31:0] out_val_ff;
   always_ff @(posedge clock) begin
      if (reset) out_v_ff <= 1'b0;
      else if (en) out_v_ff <= t_v_ff;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         out_word_ff <= t_word_ff;
         out_val_ff  <= o_val;
      end
   end

   assign rsp.valid       = out_v_ff;
   assign rsp.word        = out_word_ff;
   assign rsp.label_out   = out_word_ff[7:0];
   assign rsp.sdi_out     = out_word_ff[9:8];
   assign rsp.ssm_out     = out_word_ff[30:29];
   assign rsp.data_valid  = out_word_ff[30];
   assign rsp.data_sext   = out_word_ff[28:10];
   assign rsp.value_out   = out_val_ff;

endmodule

// ----- rtl/core/a429_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// a429_checker
// Port-level checks on the codec response channel and request ready.
// ----------------------------------------------------------------------------
module a429_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        req_ready,
   input logic [31:0] rsp_word,
   input logic [7:0]  rsp_label_out,
   input logic [1:0]  rsp_ssm_out,
   input logic        rsp_data_valid
);

   a_reset_empty: assert property (@(posedge clock) !reset && $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_label_out == rsp_word[7:0]) && (rsp_ssm_out == rsp_word[30:29])
                    && (rsp_data_valid == rsp_word[30]))
      else $error("response fields disagree with word");

   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty output");

endmodule

bind arinc429_word_codec a429_checker u_a429_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp.valid),
   .rsp_ready      (rsp.ready),
   .req_ready      (req.ready),
   .rsp_word       (rsp.word),
   .rsp_label_out  (rsp.label_out),
   .rsp_ssm_out    (rsp.ssm_out),
   .rsp_data_valid (rsp.data_valid)
);
